### design/sfrsc_pkg.sv
package sfrsc_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam logic [6:0]  LenReset = 7'd14;
  localparam logic [6:0]  LenMin = 7'd6;

  typedef enum logic [CfgIdxW-1:0] {
    REG_START_CODE   = 3'd0,
    REG_SLAVE_ADDR   = 3'd1,
    REG_RUNTIME_CMD  = 3'd2,
    REG_SYSTEM_CMD   = 3'd3,
    REG_RUNTIME_LEN  = 3'd4,
    REG_SYSTEM_LEN   = 3'd5,
    REG_END_CODE     = 3'd6
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_ACCEPTED   = 3'd0,
    ST_HDR_REJECT = 3'd1,
    ST_FRAME_OK   = 3'd2,
    ST_SUM_BAD    = 3'd3,
    ST_END_BAD    = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] start_code;
    logic [7:0] slave_address;
    logic [7:0] runtime_command;
    logic [7:0] system_command;
    logic [6:0] runtime_length;
    logic [6:0] system_length;
    logic [7:0] end_code;
  } cfg_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic [5:0] byte_position;
    logic       frame_kind;
    status_e    status;
  } res_t;

endpackage

### design/sfrsc_frame_core.sv
module sfrsc_frame_core #(
  parameter int unsigned MAX_FRAME_LEN = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          take_i,
  input  logic [7:0]    rx_byte_i,
  input  sfrsc_pkg::cfg_t cfg_i,
  output sfrsc_pkg::res_t res_o
);
  import sfrsc_pkg::*;

  localparam logic [6:0] LenMax = (MAX_FRAME_LEN > 127) ? 7'd127 : 7'(MAX_FRAME_LEN);

  logic [6:0]  pos_q, pos_d;
  logic [6:0]  len_q, len_d;
  logic        kind_q, kind_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  lo_q, lo_d;
  logic [7:0]  hi_q, hi_d;
  logic        take_byte;
  status_e     status;
  logic [7:0]  p8;
  logic [7:0]  l8;
  logic [7:0]  el8;

  function automatic logic [6:0] clamp_len(input logic [6:0] len);
    logic [6:0] r;
    r = len;
    if (len < LenMin) r = LenMin;
    else if (len > LenMax) r = LenMax;
    return r;
  endfunction

  assign p8  = {1'b0, pos_q};
  assign l8  = {1'b0, len_q};

  always_comb begin
    pos_d     = pos_q;
    len_d     = len_q;
    kind_d    = kind_q;
    sum_d     = sum_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    status    = ST_ACCEPTED;
    take_byte = 1'b0;
    if (pos_q == 7'd0) begin
      if (rx_byte_i == cfg_i.start_code) begin
        sum_d  = '0;
        kind_d = 1'b0;
        pos_d  = 7'd1;
      end else begin
        status = ST_HDR_REJECT;
      end
    end else if (pos_q == 7'd1) begin
      if (rx_byte_i == cfg_i.slave_address) begin
        sum_d = sum_q + {8'd0, rx_byte_i};
        pos_d = 7'd2;
      end else begin
        status = ST_HDR_REJECT;
        kind_d = 1'b0;
        pos_d  = 7'd0;
      end
    end else if (pos_q == 7'd2) begin
      if (rx_byte_i == cfg_i.runtime_command) begin
        kind_d    = 1'b0;
        len_d     = clamp_len(cfg_i.runtime_length);
        take_byte = 1'b1;
        pos_d     = 7'd3;
      end else if (rx_byte_i == cfg_i.system_command) begin
        kind_d    = 1'b1;
        len_d     = clamp_len(cfg_i.system_length);
        take_byte = 1'b1;
        pos_d     = 7'd3;
      end else begin
        status = ST_HDR_REJECT;
        kind_d = 1'b0;
        pos_d  = 7'd0;
      end
    end else if (p8 + 8'd1 < l8) begin
      take_byte = 1'b1;
      pos_d     = pos_q + 7'd1;
    end else if (p8 + 8'd1 == l8) begin
      if (rx_byte_i != cfg_i.end_code) status = ST_END_BAD;
      else if (sum_q[7:0] == lo_q && sum_q[15:8] == hi_q) status = ST_FRAME_OK;
      else status = ST_SUM_BAD;
      pos_d = 7'd0;
    end else begin
      status = ST_HDR_REJECT;
      kind_d = 1'b0;
      pos_d  = 7'd0;
    end
    el8 = {1'b0, len_d};
    if (take_byte) begin
      if (p8 + 8'd5 <= el8) sum_d = sum_q + {8'd0, rx_byte_i};
      if (p8 + 8'd4 == el8) lo_d = rx_byte_i;
      if (p8 + 8'd3 == el8) hi_d = rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      len_q  <= '0;
      kind_q <= 1'b0;
      sum_q  <= '0;
      lo_q   <= '0;
      hi_q   <= '0;
    end else if (take_i) begin
      pos_q  <= pos_d;
      len_q  <= len_d;
      kind_q <= kind_d;
      sum_q  <= sum_d;
      lo_q   <= lo_d;
      hi_q   <= hi_d;
    end
  end

  assign res_o.payload_byte  = rx_byte_i;
  assign res_o.byte_position = pos_q[5:0];
  assign res_o.frame_kind    = kind_d;
  assign res_o.status        = status;

endmodule

### design/serial_frame_receiver_sum_check_unit.sv
// Serial frame receiver with a 16-bit wrapping sum check.
//
// Input channel (in_valid_i / in_ready_o / rx_byte_i) takes one received
// byte per item. Each byte yields exactly one result item on the output
// channel (out_valid_o / out_ready_i): the byte echoed, its position in the
// frame, the frame kind and a status (accepted, header rejected, frame ok,
// checksum bad, end code bad).
// The result is registered: a byte taken in one cycle is shown at the
// output in the next. Throughput is one item per cycle while the output
// register drains; the frame state and the sum update in a single pass
// between the frame state and the output register.
// When the receiver stalls, the result holds in the output register and a
// new byte is taken only in a cycle where that register is drained.
// Reset clears the frame state to position zero and loads the register
// defaults (lengths 14, all codes zero). Registers are written through the
// cfg channel, always ready; the user must write them only while the block is idle, which the block does not enforce.
module serial_frame_receiver_sum_check_unit #(
  parameter int unsigned MAX_FRAME_LEN = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   rx_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [7:0]                   payload_byte_o,
  output logic [5:0]                   byte_position_o,
  output logic                         frame_kind_o,
  output logic [2:0]                   status_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [sfrsc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                   cfg_data_i
);
  import sfrsc_pkg::*;

  cfg_t cfg_q;
  res_t res;
  res_t res_q;
  logic out_valid_q;
  logic in_fire;
  logic out_fire;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_code      <= '0;
      cfg_q.slave_address   <= '0;
      cfg_q.runtime_command <= '0;
      cfg_q.system_command  <= '0;
      cfg_q.runtime_length  <= LenReset;
      cfg_q.system_length   <= LenReset;
      cfg_q.end_code        <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_START_CODE:  cfg_q.start_code      <= cfg_data_i;
        REG_SLAVE_ADDR:  cfg_q.slave_address   <= cfg_data_i;
        REG_RUNTIME_CMD: cfg_q.runtime_command <= cfg_data_i;
        REG_SYSTEM_CMD:  cfg_q.system_command  <= cfg_data_i;
        REG_RUNTIME_LEN: cfg_q.runtime_length  <= cfg_data_i[6:0];
        REG_SYSTEM_LEN:  cfg_q.system_length   <= cfg_data_i[6:0];
        REG_END_CODE:    cfg_q.end_code        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sfrsc_frame_core #(
    .MAX_FRAME_LEN(MAX_FRAME_LEN)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (in_fire),
    .rx_byte_i(rx_byte_i),
    .cfg_i    (cfg_q),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign payload_byte_o  = res_q.payload_byte;
  assign byte_position_o = res_q.byte_position;
  assign frame_kind_o    = res_q.frame_kind;
  assign status_o        = res_q.status;

  a_reject_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && res.status != ST_ACCEPTED) |=> (res.byte_position == 6'd0))
    else $error("frame position not returned to zero after a closing status");

  a_fire_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_o)
    else $error("accepted item not presented");

  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !in_fire) |=> !out_valid_o)
    else $error("taken item presented again");

endmodule

### tb/tb_serial_frame_receiver_sum_check_unit.sv
`timescale 1ns / 1ps

module tb_serial_frame_receiver_sum_check_unit;
  import sfrsc_pkg::*;

  localparam int unsigned MaxFrameLen = 64;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseBytes = 185;

  typedef struct {
    bit         is_reg;
    cfg_reg_e   idx;
    logic [7:0] val;
    bit         typed;
    logic [5:0] pos;
    logic       kind;
    status_e    st;
  } stim_row_t;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [7:0]         rx_byte_i = 8'h00;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [7:0]         payload_byte_o;
  logic [5:0]         byte_position_o;
  logic               frame_kind_o;
  logic [2:0]         status_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = REG_START_CODE;
  logic [7:0]         cfg_data_i = 8'h00;

  cfg_t regs = '{8'h00, 8'h00, 8'h00, 8'h00, LenReset, LenReset, 8'h00};

  logic [6:0]  frame_pos = '0;
  logic [6:0]  frame_len = '0;
  logic        frame_kind = 1'b0;
  logic [15:0] frame_sum = '0;
  logic [7:0]  check_lo = '0;
  logic [7:0]  check_hi = '0;

  res_t        pending_results [$];
  res_t        want;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned burst_left = 0;
  int unsigned max_gap = 3;
  int unsigned rx_mode = 1;

  stim_row_t directed_rows [24] = '{
    '{1'b0, REG_START_CODE, 8'hFF, 1'b1, 6'd0, 1'b0, ST_HDR_REJECT},
    '{1'b0, REG_START_CODE, 8'h00, 1'b1, 6'd0, 1'b0, ST_ACCEPTED},
    '{1'b0, REG_START_CODE, 8'h80, 1'b1, 6'd1, 1'b0, ST_HDR_REJECT},
    '{1'b1, REG_RUNTIME_LEN, 8'h00, 1'b0, 6'd0, 1'b0, ST_ACCEPTED},
    '{1'b1, REG_SYSTEM_LEN, 8'hFF, 1'b0, 6'd0, 1'b0, ST_ACCEPTED},
    '{1'b1, REG_END_CODE, 8'hAA, 1'b0, 6'd0, 1'b0, ST_ACCEPTED},
    '{1'b0, REG_START_CODE, 8'h00, 1'b1, 6'd0, 1'b0, ST_ACCEPTED},
    '{1'b0, REG_START_CODE, 8'h00, 1'b1, 6'd1, 1'b0, ST_ACCEPTED},
    '{1'b0, REG_START_CODE, 8'h00, 1'b1, 6'd2, 1'b0, ST_ACCEPTED},
    '{1'b0, REG_START_CODE, 8'h00, 1'b1, 6'd3, 1'b0, ST_ACCEPTED},
    '{1'b0, REG_START_CODE, 8'h33, 1'b0, 6'd4, 1'b0, ST_ACCEPTED},
    '{1'b0, REG_START_CODE, 8'hAA, 1'b1, 6'd5, 1'b0, ST_FRAME_OK},
    '{1'b0, REG_START_CODE, 8'h00, 1'b1, 6'd0, 1'b0, ST_ACCEPTED},
    '{1'b0, REG_START_CODE, 8'h00, 1'b1, 6'd1, 1'b0, ST_ACCEPTED},
    '{1'b0, REG_START_CODE, 8'h00, 1'b1, 6'd2, 1'b0, ST_ACCEPTED},
    '{1'b0, REG_START_CODE, 8'h01, 1'b1, 6'd3, 1'b0, ST_ACCEPTED},
    '{1'b0, REG_START_CODE, 8'h33, 1'b0, 6'd4, 1'b0, ST_ACCEPTED},
    '{1'b0, REG_START_CODE, 8'hAA, 1'b1, 6'd5, 1'b0, ST_SUM_BAD},
    '{1'b0, REG_START_CODE, 8'h00, 1'b1, 6'd0, 1'b0, ST_ACCEPTED},
    '{1'b0, REG_START_CODE, 8'h00, 1'b1, 6'd1, 1'b0, ST_ACCEPTED},
    '{1'b0, REG_START_CODE, 8'h00, 1'b1, 6'd2, 1'b0, ST_ACCEPTED},
    '{1'b0, REG_START_CODE, 8'h00, 1'b1, 6'd3, 1'b0, ST_ACCEPTED},
    '{1'b0, REG_START_CODE, 8'h33, 1'b0, 6'd4, 1'b0, ST_ACCEPTED},
    '{1'b0, REG_START_CODE, 8'h55, 1'b1, 6'd5, 1'b0, ST_END_BAD}
  };

  serial_frame_receiver_sum_check_unit #(
    .MAX_FRAME_LEN(MaxFrameLen)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .payload_byte_o (payload_byte_o),
    .byte_position_o(byte_position_o),
    .frame_kind_o   (frame_kind_o),
    .status_o       (status_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [6:0] clamp_len(logic [6:0] len);
    int unsigned top;
    top = (MaxFrameLen > 127) ? 127 : MaxFrameLen;
    if (len < LenMin) return LenMin;
    if (len > top) return 7'(top);
    return len;
  endfunction

  function automatic void take_checked(int unsigned p, logic [7:0] b);
    if (p >= 1 && p + 5 <= frame_len) frame_sum += 16'(b);
    if (p + 4 == frame_len) check_lo = b;
    if (p + 3 == frame_len) check_hi = b;
  endfunction

  function automatic res_t track_frame_byte(logic [7:0] b);
    int unsigned p;
    status_e     st;
    p  = frame_pos;
    st = ST_ACCEPTED;
    if (p == 0) begin
      if (b == regs.start_code) begin
        frame_sum  = '0;
        frame_kind = 1'b0;
        frame_pos  = 7'd1;
      end else begin
        st = ST_HDR_REJECT;
      end
    end else if (p == 1) begin
      if (b == regs.slave_address) begin
        frame_sum += 16'(b);
        frame_pos  = 7'd2;
      end else begin
        st         = ST_HDR_REJECT;
        frame_kind = 1'b0;
        frame_pos  = '0;
      end
    end else if (p == 2) begin
      if (b == regs.runtime_command || b == regs.system_command) begin
        if (b == regs.runtime_command) begin
          frame_kind = 1'b0;
          frame_len  = clamp_len(regs.runtime_length);
        end else begin
          frame_kind = 1'b1;
          frame_len  = clamp_len(regs.system_length);
        end
        take_checked(p, b);
        frame_pos = 7'd3;
      end else begin
        st         = ST_HDR_REJECT;
        frame_kind = 1'b0;
        frame_pos  = '0;
      end
    end else if (p + 1 < frame_len) begin
      take_checked(p, b);
      frame_pos = 7'(p + 1);
    end else if (p + 1 == frame_len) begin
      if (b != regs.end_code) st = ST_END_BAD;
      else if (frame_sum == {check_hi, check_lo}) st = ST_FRAME_OK;
      else st = ST_SUM_BAD;
      frame_pos = '0;
    end else begin
      st         = ST_HDR_REJECT;
      frame_kind = 1'b0;
      frame_pos  = '0;
    end
    return '{b, 6'(p), frame_kind, st};
  endfunction

  function automatic void flag_mismatch(string field, int unsigned exp_val, int unsigned got);
    $error("%s: expected %0d, got %0d", field, exp_val, got);
    mismatch_count++;
  endfunction

  function automatic logic [7:0] pick_len();
    case ($urandom_range(0, 9))
      0: return 8'($urandom_range(0, 5));
      1: return 8'($urandom_range(65, 255));
      2: return 8'($urandom_range(21, 64));
      default: return 8'($urandom_range(6, 20));
    endcase
  endfunction

  task automatic write_reg(input cfg_reg_e idx, input logic [7:0] data);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_START_CODE:  regs.start_code = data;
      REG_SLAVE_ADDR:  regs.slave_address = data;
      REG_RUNTIME_CMD: regs.runtime_command = data;
      REG_SYSTEM_CMD:  regs.system_command = data;
      REG_RUNTIME_LEN: regs.runtime_length = data[6:0];
      REG_SYSTEM_LEN:  regs.system_length = data[6:0];
      REG_END_CODE:    regs.end_code = data;
      default: ;
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b, output res_t pred);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    pred = track_frame_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame();
    logic [7:0]  fb [$];
    logic [7:0]  frm [$];
    logic [15:0] sum;
    int unsigned len;
    bit          sys;
    res_t        pred;
    sys = 1'($urandom_range(0, 1));
    if (sys && regs.system_command != regs.runtime_command)
      len = clamp_len(regs.system_length);
    else
      len = clamp_len(regs.runtime_length);
    frm.push_back(regs.start_code);
    frm.push_back(regs.slave_address);
    frm.push_back(sys ? regs.system_command : regs.runtime_command);
    for (int i = 3; i < len; i++) frm.push_back(8'($urandom));
    sum = '0;
    for (int i = 1; i + 5 <= len; i++) sum += 16'(frm[i]);
    // length six puts the low check byte on the command byte
    if (len > 6) frm[len-4] = sum[7:0];
    frm[len-3] = sum[15:8];
    frm[len-1] = regs.end_code;
    case ($urandom_range(0, 15))
      0: frm[$urandom_range(0, len - 1)] ^= 8'h01 << $urandom_range(0, 7);
      1: frm[len-1] = 8'($urandom);
      2: repeat ($urandom_range(1, len - 1)) void'(frm.pop_back());
      3: frm[$urandom_range(3, len - 2)] = 8'($urandom);
      default: ;
    endcase
    repeat (($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0) fb.push_back(8'($urandom));
    foreach (frm[i]) fb.push_back(frm[i]);
    foreach (fb[i]) begin
      send_byte(fb[i], pred);
      pending_results.push_back(pred);
    end
  endtask

  task automatic run_phase(input logic [7:0] s_code, input logic [7:0] addr,
                           input logic [7:0] rt_cmd, input logic [7:0] sys_cmd,
                           input logic [7:0] rt_len, input logic [7:0] sys_len,
                           input logic [7:0] e_code, input int unsigned gap_max,
                           input int unsigned stall_mode);
    int unsigned target;
    write_reg(REG_START_CODE, s_code);
    write_reg(REG_SLAVE_ADDR, addr);
    write_reg(REG_RUNTIME_CMD, rt_cmd);
    write_reg(REG_SYSTEM_CMD, sys_cmd);
    write_reg(REG_RUNTIME_LEN, rt_len);
    write_reg(REG_SYSTEM_LEN, sys_len);
    write_reg(REG_END_CODE, e_code);
    max_gap = gap_max;
    rx_mode = stall_mode;
    target  = bytes_sent + PhaseBytes;
    while (bytes_sent < target) send_frame();
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    case (rx_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 9) < 7);
      2: out_ready_i <= ((cycle_count % 7) < 4);
      default: out_ready_i <= ($urandom_range(0, 19) == 0);
    endcase
    if (cycle_count == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected item, payload_byte", 0, payload_byte_o);
      end else begin
        want = pending_results.pop_front();
        if (payload_byte_o !== want.payload_byte)
          flag_mismatch("payload_byte", want.payload_byte, payload_byte_o);
        if (byte_position_o !== want.byte_position)
          flag_mismatch("byte_position", want.byte_position, byte_position_o);
        if (frame_kind_o !== want.frame_kind)
          flag_mismatch("frame_kind", want.frame_kind, frame_kind_o);
        if (status_o !== want.status)
          flag_mismatch("status", want.status, status_o);
      end
    end
  end

  initial begin
    res_t        pred;
    logic [7:0]  rt;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_reg) begin
        write_reg(directed_rows[i].idx, directed_rows[i].val);
      end else begin
        send_byte(directed_rows[i].val, pred);
        if (directed_rows[i].typed)
          pred = '{directed_rows[i].val, directed_rows[i].pos, directed_rows[i].kind,
                   directed_rows[i].st};
        pending_results.push_back(pred);
      end
    end

    run_phase(8'h00, 8'h00, 8'h00, 8'hFF, 8'h86, 8'h06, 8'h00, 0, 0);
    run_phase(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h40, 8'hFF, 8'hFF, 4, 1);
    for (int k = 0; k < 6; k++) begin
      rt = 8'($urandom);
      run_phase(8'($urandom), 8'($urandom), rt, (k == 0) ? rt : 8'($urandom),
                pick_len(), pick_len(), 8'($urandom), (k % 3) * 3, (k + 2) % 4);
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### serial_frame_receiver_sum_check_unit.f
design/sfrsc_pkg.sv
design/sfrsc_frame_core.sv
design/serial_frame_receiver_sum_check_unit.sv
tb/tb_serial_frame_receiver_sum_check_unit.sv
